// ===== src/grfi_pkg.sv =====
// ============================================================================
// grfi_pkg
// Shared types, constants and coefficient tables for the gyro rate filter
// and heading integrator.
// ============================================================================
package grfi_pkg;

    localparam int TAPS      = 10;
    localparam int IDX_W     = 4;
    localparam int MUL_W     = 27;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SUM_W     = 20;

    // half divisor added to the rounding compensation
    localparam logic [14:0] HALF_DIV    = 15'd5170;
    // rounding for the tap products scaled by 10000
    localparam logic [27:0] TAP_ROUND   = 28'd5000;

    // floor(n / 10340) = ((n >> 2) * INC_RECIP) >> INC_SHIFT, exact for n < 2^28
    localparam logic [26:0] INC_RECIP   = 27'd106335748;
    localparam int          INC_SHIFT   = 38;
    // floor(n / 10000) = ((n >> 4) * TAP_RECIP) >> TAP_SHIFT, exact for n < 2^28
    localparam logic [24:0] TAP_RECIP   = 25'd27487791;
    localparam int          TAP_SHIFT   = 34;

    localparam logic [15:0] WRAP_LIMIT  = 16'd36000;
    localparam logic [15:0] WRAP_NEG    = 16'd29536;

    typedef enum logic [1:0] {
        REG_REFERENCE = 2'd0,
        REG_ZERO      = 2'd1,
        REG_COMP      = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [9:0]  reference_level;
        logic [9:0]  zero_level;
        logic [13:0] rounding_comp;
    } cfg_t;

    // classified request as it travels from front to back
    typedef struct packed {
        logic [15:0] elapsed_time;
        logic [9:0]  abs_diff;
        logic        diff_neg;
        logic        off_pos;
        logic [14:0] offset;
    } q_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL,
        B_NUM,
        B_DIV,
        B_SHIFT,
        B_TAP,
        B_RND,
        B_RDIV,
        B_LAST,
        B_WRAP
    } back_state_t;

    // magnitudes of the symmetric fir coefficients, scaled by 10000
    function automatic logic [12:0] coef_mag(input logic [IDX_W-1:0] idx);
        logic [12:0] m;
        begin
            case (idx)
                4'd0, 4'd9: m = 13'd50;
                4'd1, 4'd8: m = 13'd32;
                4'd2, 4'd7: m = 13'd580;
                4'd3, 4'd6: m = 13'd583;
                4'd4, 4'd5: m = 13'd4915;
                default:    m = 13'd0;
            endcase
            return m;
        end
    endfunction

    function automatic logic coef_neg(input logic [IDX_W-1:0] idx);
        begin
            return (idx == 4'd2) || (idx == 4'd7);
        end
    endfunction

endpackage

// ===== src/gyro_rate_fir_angle_integrator.sv =====
// ============================================================================
// gyro_rate_fir_angle_integrator
// Gyro rate to heading integrator with a ten-tap symmetric fir smoother.
// ============================================================================
// Each request carries one gyro rate sample and the elapsed time; it yields
// exactly one result with the wrapped heading (0..35999 hundredths of a
// degree) and the filtered step added to it. In the back end one shared
// 27x27 multiplier forms the rate product and the reciprocal division of
// the increment (after the queue pop), then serves each of the ten taps in
// turn (coefficient product, rounding, reciprocal division); the sum of the
// taps is then closed and the heading wrapped. A two-entry queue
// lets the input side take requests while the back end works, and an output
// register holds a finished result until the sink takes it. Registers sit
// at byte addresses 0 (reference_level), 4 (zero_level) and 8
// (rounding_comp) and should be written only while the block is idle.
module gyro_rate_fir_angle_integrator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // rate_sample[9:0], elapsed_time[25:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // heading[15:0], filtered_step[31:16]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import grfi_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       cfg_wr;
    q_item_t    front_item;
    q_item_t    queue_item;
    q_status_t  q_stat;
    logic       push;
    logic       pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (paddr[3:2])
            REG_REFERENCE:
            begin
                prdata = {22'd0, cfg_reg.reference_level};
                if (cfg_wr)
                begin
                    cfg_next.reference_level = pwdata[9:0];
                end
            end
            REG_ZERO:
            begin
                prdata = {22'd0, cfg_reg.zero_level};
                if (cfg_wr)
                begin
                    cfg_next.zero_level = pwdata[9:0];
                end
            end
            REG_COMP:
            begin
                prdata = {18'd0, cfg_reg.rounding_comp};
                if (cfg_wr)
                begin
                    cfg_next.rounding_comp = pwdata[13:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reference_level <= 10'd512;
            cfg_reg.zero_level      <= 10'd512;
            cfg_reg.rounding_comp   <= 14'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    grfi_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg_reg),
        .q_stat   (q_stat),
        .push     (push),
        .item     (front_item)
    );

    grfi_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .pop_item  (queue_item),
        .q_stat    (q_stat)
    );

    grfi_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_item   (queue_item),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("request popped from an empty queue");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !q_stat.empty)
        else $error("accepted request missing from queue");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:0] < WRAP_LIMIT))
        else $error("heading outside wrap range");

endmodule

// ===== src/grfi_front.sv =====
// ============================================================================
// grfi_front
// Accepts gyro requests and classifies them against the configured zero and
// reference levels before they enter the queue.
// ============================================================================
module grfi_front
(
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,    // rate_sample[9:0], elapsed_time[25:10]
    input  grfi_pkg::cfg_t      cfg,
    input  grfi_pkg::q_status_t q_stat,
    output logic                push,
    output grfi_pkg::q_item_t   item
);
    import grfi_pkg::*;

    logic [9:0]  sample;
    logic [10:0] diff;

    assign sample   = s_tdata[9:0];
    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        diff              = {1'b0, sample} - {1'b0, cfg.zero_level};
        item.elapsed_time = s_tdata[25:10];
        item.diff_neg     = diff[10];
        item.abs_diff     = diff[10] ? 10'(~diff + 11'd1) : diff[9:0];
        item.off_pos      = (sample >= cfg.reference_level);
        item.offset       = HALF_DIV + {1'b0, cfg.rounding_comp};
    end

endmodule

// ===== src/grfi_queue.sv =====
// ============================================================================
// grfi_queue
// Two-entry queue of classified requests between front and back.
// ============================================================================
module grfi_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  grfi_pkg::q_item_t   push_item,
    input  logic                pop,
    output grfi_pkg::q_item_t   pop_item,
    output grfi_pkg::q_status_t q_stat
);
    import grfi_pkg::*;

    q_item_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);
    assign pop_item     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/grfi_back.sv =====
// ============================================================================
// grfi_back
// Sequencer around one shared multiplier: forms the angle increment, runs
// the ten-tap fir with per-tap rounding and integrates the heading.
// ============================================================================
module grfi_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  grfi_pkg::q_item_t   q_item,
    input  grfi_pkg::q_status_t q_stat,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata     // heading[15:0], filtered_step[31:16]
);
    import grfi_pkg::*;

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [15:0]        taps_reg [TAPS];
    logic [15:0]        taps_next [TAPS];
    logic [15:0]        angle_reg;
    logic [15:0]        angle_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [31:0]        out_data_reg;
    logic [31:0]        out_data_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;

    q_item_t            item_reg;
    q_item_t            item_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic [25:0]        x_reg;
    logic [25:0]        x_next;
    logic               neg_reg;
    logic               neg_next;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;

    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  product;
    logic [27:0]        p3;
    logic [29:0]        sp;
    logic [29:0]        so;
    logic [29:0]        n30;
    logic [29:0]        nmag;
    logic [14:0]        q_inc;
    logic [14:0]        q_tap;
    logic [SUM_W-1:0]   term;
    logic [15:0]        tap_sel;
    logic [15:0]        tap_mag;
    logic [27:0]        rsum;
    logic [15:0]        step;
    logic [15:0]        acc;
    logic               out_free;

    assign product  = mul_a * mul_b;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        tap_sel = taps_reg[idx_reg];
        tap_mag = tap_sel[15] ? (~tap_sel + 16'd1) : tap_sel;
        q_inc   = prod_reg[INC_SHIFT +: 15];
        q_tap   = prod_reg[TAP_SHIFT +: 15];
        term    = neg_reg ? (~{5'd0, q_tap} + SUM_W'(1)) : {5'd0, q_tap};
        p3      = {2'b0, prod_reg[25:0]} + {1'b0, prod_reg[25:0], 1'b0};
        sp      = {2'b0, p3};
        so      = {15'd0, item_reg.offset};
        n30     = (item_reg.diff_neg ? (~sp + 30'd1) : sp)
                + (item_reg.off_pos ? so : (~so + 30'd1));
        nmag    = n30[29] ? (~n30 + 30'd1) : n30;
        rsum    = prod_reg[27:0] + TAP_ROUND;
        step    = sum_reg[15:0];
        acc     = angle_reg + step;
        if (acc >= WRAP_LIMIT)
        begin
            acc = step[15] ? (acc - WRAP_NEG) : (acc - WRAP_LIMIT);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        taps_next      = taps_reg;
        angle_next     = angle_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        idx_next       = idx_reg;
        item_next      = item_reg;
        prod_next      = prod_reg;
        x_next         = x_reg;
        neg_next       = neg_reg;
        sum_next       = sum_reg;
        pop            = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    item_next  = q_item;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                mul_a      = {11'd0, item_reg.elapsed_time};
                mul_b      = {17'd0, item_reg.abs_diff};
                prod_next  = product;
                state_next = B_NUM;
            end
            B_NUM:
            begin
                // divide by 10340 as quarter then 2585 through the reciprocal
                neg_next   = n30[29];
                x_next     = nmag[27:2];
                state_next = B_DIV;
            end
            B_DIV:
            begin
                mul_a      = {1'b0, x_reg};
                mul_b      = INC_RECIP;
                prod_next  = product;
                state_next = B_SHIFT;
            end
            B_SHIFT:
            begin
                for (int i = 0; i < TAPS - 1; i++)
                begin
                    taps_next[i] = taps_reg[i + 1];
                end
                taps_next[TAPS-1] = neg_reg ? (~{1'b0, q_inc} + 16'd1) : {1'b0, q_inc};
                idx_next   = '0;
                sum_next   = '0;
                state_next = B_TAP;
            end
            B_TAP:
            begin
                // fold in the previous tap while its quotient is still in prod_reg
                if (idx_reg != '0)
                begin
                    sum_next = sum_reg + term;
                end
                mul_a      = {11'd0, tap_mag};
                mul_b      = {14'd0, coef_mag(idx_reg)};
                prod_next  = product;
                neg_next   = tap_sel[15] ^ coef_neg(idx_reg);
                state_next = B_RND;
            end
            B_RND:
            begin
                x_next     = {2'b0, rsum[27:4]};
                state_next = B_RDIV;
            end
            B_RDIV:
            begin
                mul_a     = {1'b0, x_reg};
                mul_b     = {2'b0, TAP_RECIP};
                prod_next = product;
                if (idx_reg == IDX_W'(TAPS - 1))
                begin
                    state_next = B_LAST;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = B_TAP;
                end
            end
            B_LAST:
            begin
                sum_next   = sum_reg + term;
                state_next = B_WRAP;
            end
            B_WRAP:
            begin
                if (out_free)
                begin
                    angle_next     = acc;
                    out_valid_next = 1'b1;
                    out_data_next  = {step, acc};
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            angle_reg     <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            for (int i = 0; i < TAPS; i++)
            begin
                taps_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            angle_reg     <= angle_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            taps_reg      <= taps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        item_reg     <= item_next;
        prod_reg     <= prod_next;
        x_reg        <= x_next;
        neg_reg      <= neg_next;
        sum_reg      <= sum_next;
    end

endmodule
